/* hw/rtl/pid_controller_step_macros.svh */
// Assertion macros shared by the checker files of the PID step block.
// No dependencies; take in with `include before use.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PID_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pid_pkg.sv */
// Shared widths, constants and controller/datapath interface types
// for the PID step block. No dependencies.
package pid_pkg;

    localparam int unsigned ErrW     = 16;
    localparam int unsigned DtW      = 16;
    localparam int unsigned GainW    = 16;
    localparam int unsigned SumW     = 32;
    localparam int unsigned CmdW     = 32;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned InDataW  = ErrW + DtW;
    localparam int unsigned OutUserW = 2;

    // shared multiplier: 34b signed x 18b signed
    localparam int unsigned MulAW = 34;
    localparam int unsigned MulBW = 18;
    localparam int unsigned ProdW = MulAW + MulBW;
    localparam int unsigned HalfW = 16;

    localparam int unsigned DerivW = ErrW + 1;
    localparam int unsigned M1W    = GainW + DtW + 1;
    localparam int unsigned AccW   = 64;
    localparam int unsigned IShift = 24;
    localparam int unsigned PShift = 8;
    localparam int unsigned PW     = 2 * ErrW - PShift;
    localparam int unsigned IW     = AccW - IShift;
    localparam int unsigned NumW   = GainW + DerivW;
    localparam int unsigned QuoW   = 40;
    localparam int unsigned DW     = QuoW + 1;
    localparam int unsigned TotW   = 43;

    localparam int unsigned DivSteps = QuoW;
    localparam int unsigned CntW     = $clog2(DivSteps);

    localparam logic signed [GainW-1:0] KP_RESET = 16'sd256;
    localparam logic signed [GainW-1:0] KI_RESET = 16'sd0;
    localparam logic signed [GainW-1:0] KD_RESET = -16'sd9;

    localparam logic [SumW-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [SumW-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECODE,
        OP_MUL_P,
        OP_MUL_KI,
        OP_SAVE_M1,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_KD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIX_D,
        OP_SUM
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic dt_zero;
    } t_dp_status;

endpackage

/* hw/rtl/pid_ctrl.sv */
// Sequencer for the PID step: walks the datapath through one request.
// Depends on pid_pkg.
module pid_ctrl
    import pid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_P,
        S_MUL_KI,
        S_SAVE_M1,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_KD,
        S_DIV_INIT,
        S_DIV,
        S_FIX_D,
        S_SUM,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_cnt;
    logic            r_out_valid;
    logic            w_out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // result register is free when empty or being drained this cycle
    assign w_out_load  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.out_load = w_out_load;
        case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_DECODE:   o_cmd.op = OP_DECODE;
            S_MUL_P:    o_cmd.op = OP_MUL_P;
            S_MUL_KI:   o_cmd.op = OP_MUL_KI;
            S_SAVE_M1:  o_cmd.op = OP_SAVE_M1;
            S_MUL_LO:   o_cmd.op = OP_MUL_LO;
            S_MUL_HI:   o_cmd.op = OP_MUL_HI;
            S_MUL_KD:   o_cmd.op = OP_MUL_KD;
            S_DIV_INIT: o_cmd.op = OP_DIV_INIT;
            S_DIV:      o_cmd.op = OP_DIV_STEP;
            S_FIX_D:    o_cmd.op = OP_FIX_D;
            S_SUM:      o_cmd.op = OP_SUM;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a load refills the register in the same cycle it drains
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    if (i_status.is_clear || i_status.dt_zero) r_state <= S_FINISH;
                    else r_state <= S_MUL_P;
                end
                S_MUL_P:   r_state <= S_MUL_KI;
                S_MUL_KI:  r_state <= S_SAVE_M1;
                S_SAVE_M1: r_state <= S_MUL_LO;
                S_MUL_LO:  r_state <= S_MUL_HI;
                S_MUL_HI:  r_state <= S_MUL_KD;
                S_MUL_KD:  r_state <= S_DIV_INIT;
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CntW'(DivSteps - 1)) r_state <= S_FIX_D;
                end
                S_FIX_D: r_state <= S_SUM;
                S_SUM:   r_state <= S_FINISH;
                S_FINISH: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/pid_datapath.sv */
// PID step datapath: gains, loop state, shared multiplier, restoring
// divider and result register. Depends on pid_pkg.
module pid_datapath
    import pid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [GainW-1:0]    i_cfg_data,
    input  logic [InDataW-1:0]  i_in_data,
    input  logic                i_in_user,
    output logic [CmdW-1:0]     o_out_data,
    output logic [OutUserW-1:0] o_out_user
);

    // configuration
    logic signed [GainW-1:0] r_kp, r_ki, r_kd;
    // loop state
    logic signed [SumW-1:0]  r_sum;
    logic signed [ErrW-1:0]  r_last;
    // request
    logic signed [ErrW-1:0]  r_e;
    logic [DtW-1:0]          r_dt;
    logic                    r_clear;
    // working registers
    logic signed [DerivW-1:0] r_deriv;
    logic                     r_sat;
    logic signed [ProdW-1:0]  r_prod;
    logic signed [PW-1:0]     r_p;
    logic signed [M1W-1:0]    r_m1;
    logic signed [AccW-1:0]   r_acc;
    logic signed [IW-1:0]     r_i;
    logic [QuoW-1:0]          r_quo;
    logic [DtW-1:0]           r_rem;
    logic                     r_neg;
    logic signed [DW-1:0]     r_d;
    logic signed [TotW-1:0]   r_tot;
    // result
    logic [CmdW-1:0]          r_out_cmd;
    logic                     r_out_sat;
    logic                     r_out_iz;

    logic                     w_dt_zero;
    logic [SumW:0]            w_sum_ext;
    logic                     w_sum_ovf;
    logic signed [MulAW-1:0]  w_mul_a;
    logic signed [MulBW-1:0]  w_mul_b;
    logic signed [ProdW-1:0]  w_prod;
    logic signed [AccW-1:0]   w_hi_sh;
    logic [NumW-1:0]          w_num;
    logic [NumW-1:0]          w_mag;
    logic [DtW:0]             w_rem_sh;
    logic [DtW:0]             w_trial;
    logic                     w_ge;
    logic [DW-1:0]            w_quo_adj;
    logic                     w_tot_ovf;

    assign w_dt_zero = (r_dt == '0);
    assign o_status.is_clear = r_clear;
    assign o_status.dt_zero  = w_dt_zero;

    assign w_sum_ext = {r_sum[SumW-1], r_sum} + {{(SumW + 1 - ErrW){r_e[ErrW-1]}}, r_e};
    assign w_sum_ovf = (w_sum_ext[SumW] != w_sum_ext[SumW-1]);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_MUL_P: begin
                w_mul_a = {{(MulAW - GainW){r_kp[GainW-1]}}, r_kp};
                w_mul_b = {{(MulBW - ErrW){r_e[ErrW-1]}}, r_e};
            end
            OP_MUL_KI: begin
                w_mul_a = {{(MulAW - GainW){r_ki[GainW-1]}}, r_ki};
                w_mul_b = {{(MulBW - DtW){1'b0}}, r_dt};
            end
            OP_MUL_LO: begin
                w_mul_a = {{(MulAW - M1W){r_m1[M1W-1]}}, r_m1};
                w_mul_b = {{(MulBW - HalfW){1'b0}}, r_sum[HalfW-1:0]};
            end
            OP_MUL_HI: begin
                w_mul_a = {{(MulAW - M1W){r_m1[M1W-1]}}, r_m1};
                w_mul_b = {{(MulBW - HalfW){r_sum[SumW-1]}}, r_sum[SumW-1:HalfW]};
            end
            OP_MUL_KD: begin
                w_mul_a = {{(MulAW - GainW){r_kd[GainW-1]}}, r_kd};
                w_mul_b = {{(MulBW - DerivW){r_deriv[DerivW-1]}}, r_deriv};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_hi_sh = {{(AccW - ProdW){r_prod[ProdW-1]}}, r_prod} <<< HalfW;

    // magnitude of kd*deriv for the divider
    assign w_num = r_prod[NumW-1:0];
    assign w_mag = w_num[NumW-1] ? (~w_num + 1'b1) : w_num;

    // one restoring step
    assign w_rem_sh = {r_rem, r_quo[QuoW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dt});
    assign w_trial  = w_rem_sh - {1'b0, r_dt};

    // negative quotient floors away from zero when inexact
    assign w_quo_adj = {1'b0, r_quo} + DW'(r_rem != '0);
    assign w_tot_ovf = (r_tot[TotW-1:CmdW-1] != {(TotW - CmdW + 1){r_tot[TotW-1]}});

    // gains and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= KP_RESET;
            r_ki   <= KI_RESET;
            r_kd   <= KD_RESET;
            r_sum  <= '0;
            r_last <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:  r_kp <= i_cfg_data;
                    CFG_KI:  r_ki <= i_cfg_data;
                    CFG_KD:  r_kd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_DECODE) begin
                if (r_clear) begin
                    r_sum  <= '0;
                    r_last <= '0;
                end else if (!w_dt_zero) begin
                    r_last <= r_e;
                    if (w_sum_ovf) r_sum <= w_sum_ext[SumW] ? S32_MIN : S32_MAX;
                    else r_sum <= w_sum_ext[SumW-1:0];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_e     <= i_in_data[ErrW-1:0];
                r_dt    <= i_in_data[InDataW-1:ErrW];
                r_clear <= i_in_user;
                r_sat   <= 1'b0;
            end
            OP_DECODE: begin
                r_deriv <= {r_e[ErrW-1], r_e} - {r_last[ErrW-1], r_last};
                r_sat   <= !r_clear && !w_dt_zero && w_sum_ovf;
            end
            OP_MUL_P: r_prod <= w_prod;
            OP_MUL_KI: begin
                r_p    <= r_prod[2*ErrW-1:PShift];
                r_prod <= w_prod;
            end
            OP_SAVE_M1: r_m1 <= r_prod[M1W-1:0];
            OP_MUL_LO:  r_prod <= w_prod;
            OP_MUL_HI: begin
                r_acc  <= {{(AccW - ProdW){r_prod[ProdW-1]}}, r_prod};
                r_prod <= w_prod;
            end
            OP_MUL_KD: begin
                r_acc  <= r_acc + w_hi_sh;
                r_prod <= w_prod;
            end
            OP_DIV_INIT: begin
                r_i   <= r_acc[AccW-1:IShift];
                r_neg <= w_num[NumW-1];
                r_quo <= {w_mag[QuoW-PShift-1:0], {PShift{1'b0}}};
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? w_trial[DtW-1:0] : w_rem_sh[DtW-1:0];
                r_quo <= {r_quo[QuoW-2:0], w_ge};
            end
            OP_FIX_D: r_d <= r_neg ? -w_quo_adj : {1'b0, r_quo};
            OP_SUM: begin
                r_tot <= {{(TotW - PW){r_p[PW-1]}}, r_p}
                       + {{(TotW - IW){r_i[IW-1]}}, r_i}
                       + {{(TotW - DW){r_d[DW-1]}}, r_d};
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_clear || w_dt_zero) begin
                r_out_cmd <= '0;
                r_out_sat <= 1'b0;
                r_out_iz  <= !r_clear;
            end else begin
                if (w_tot_ovf) r_out_cmd <= r_tot[TotW-1] ? S32_MIN : S32_MAX;
                else r_out_cmd <= r_tot[CmdW-1:0];
                r_out_sat <= r_sat || w_tot_ovf;
                r_out_iz  <= 1'b0;
            end
        end
    end

    assign o_out_data = r_out_cmd;
    assign o_out_user = {r_out_iz, r_out_sat};

endmodule

/* hw/rtl/pid_controller_step.sv */
// Top level of the positional PID steering step: sequencer plus datapath.
// Depends on pid_pkg, pid_ctrl, pid_datapath.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: angle_error, interval; tuser: action
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: command; tuser: saturated, interval_zero
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data (Q8.8 gain)
//
// A regulating request runs these steps after its accept: the shared 34x18
// multiplier runs five products (a save step stores ki*dt between the second
// and third), then the restoring divider for the derivative term runs one
// quotient bit per cycle, 40 steps.
// A clear or zero-interval request goes from decode straight to the finish step.
// Reset (sync, active low) restores the gains to 1.0 / 0 / -9/256 and zeroes
// the integral and previous error. The config port is always ready.
// A new request is taken while a finished result still waits on m_axis;
// the next result stalls in its last step until the output register frees.
module pid_controller_step
    import pid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] angle_error, [31:16] interval
    input  logic                s_axis_tuser,   // [0] action (1 = clear)
    // result out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [CmdW-1:0]     m_axis_tdata,   // [31:0] command
    output logic [OutUserW-1:0] m_axis_tuser,   // [0] saturated, [1] interval_zero
    // gain writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [GainW-1:0]    i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    pid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    pid_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

/* hw/rtl/pid_checker.sv */
// Port-level checks for the PID step top level, bound to every instance.
// Depends on pid_pkg and pid_controller_step_macros.svh.
`include "pid_controller_step_macros.svh"

module pid_checker
    import pid_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [CmdW-1:0]     m_axis_tdata,
    input logic [OutUserW-1:0] m_axis_tuser
);

    // skipped step carries a zero command and no clip flag
    `PID_ASSERT_IMPL(a_skip_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata == '0) && !m_axis_tuser[0], "skipped step with nonzero result")

    // one request at a time: input closes right after an accept
    `PID_ASSERT_NEXT(a_in_closes, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still open after accept")

    // stalled result holds
    `PID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind pid_controller_step pid_checker u_pid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/pid_controller_step_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for pid_controller_step: queued requests, clocked driver and monitor,
// in-bench PID predictor. Depends on pid_pkg and the pid_controller_step RTL only.
module pid_controller_step_test;
    import pid_pkg::*;

    localparam int  STUCK_LIMIT = 2000;     // idle cycles tolerated with no handshake anywhere
    localparam int  TAIL_CYCLES = 64;       // longer than the regulating latency
    localparam int  RAND_PHASES = 7;
    localparam int  RAND_PER_PHASE = 64;
    localparam int  CLIMB_STEPS = 40;       // held most negative error walks the integral down
    localparam int  MAX_REPORTS = 10;
    localparam longint CMD_MAX = 64'sd2147483647;
    localparam longint CMD_MIN = -64'sd2147483648;
    // index past the three gain registers; a write there must be dropped
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic              clear;
        logic [ErrW-1:0]   err;
        logic [DtW-1:0]    dt;
    } t_pid_req;

    typedef struct packed {
        logic signed [CmdW-1:0] command;
        logic                   saturated;
        logic                   interval_zero;
    } t_pid_result;

    // ---------------------------------------------------------------- DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;     // [15:0] angle_error, [31:16] interval
    logic                s_axis_tuser = 1'b0;   // [0] action (1 = clear)
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [CmdW-1:0]     m_axis_tdata;          // [31:0] command
    logic [OutUserW-1:0] m_axis_tuser;          // [0] saturated, [1] interval_zero
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [GainW-1:0]    i_cfg_data = '0;

    pid_controller_step DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ---------------------------------------------------------------- bench state
    t_pid_req    feed_q[$];         // requests waiting for the driver
    t_pid_result cmd_expect_q[$];   // predicted results, oldest first

    // predictor copy of gains and regulator state
    logic signed [GainW-1:0] kp_q = KP_RESET;
    logic signed [GainW-1:0] ki_q = KI_RESET;
    logic signed [GainW-1:0] kd_q = KD_RESET;
    logic signed [SumW-1:0]  err_sum_q = '0;
    logic signed [ErrW-1:0]  last_err_q = '0;

    // idle shaping, set by the sequencer at falling edges
    int unsigned src_pct = 20;      // chance per request of a source gap burst
    int unsigned sink_pct = 5;      // chance per cycle of a sink stall burst
    bit          quiet = 1'b0;      // last part: no idling at all
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned stuck_cycles = 0;

    // run statistics
    int unsigned req_cnt = 0, clear_cnt = 0, skip_cnt = 0;
    int unsigned sum_clip_cnt = 0, cmd_clip_cnt = 0, result_cnt = 0;
    int unsigned gain_sets = 1, err_cnt = 0;

    // ---------------------------------------------------------------- clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    // One PID step on the bench copy of the state. Each term is floored on its own,
    // then summed exactly and clipped to 32 bits.
    function automatic t_pid_result regulate_step(input logic clear,
                                                  input logic signed [ErrW-1:0] err,
                                                  input logic [DtW-1:0] dt);
        t_pid_result r;
        longint      sum, deriv, p_term, i_term, d_num, d_term, total, dt_l;
        r = '0;
        req_cnt++;
        if (clear) begin
            clear_cnt++;
            err_sum_q = '0;
            last_err_q = '0;
            return r;
        end
        if (dt == '0) begin
            // skipped step: state untouched
            skip_cnt++;
            r.interval_zero = 1'b1;
            return r;
        end
        dt_l  = longint'(dt);
        deriv = longint'(err) - longint'(last_err_q);
        last_err_q = err;

        sum = longint'(err_sum_q) + longint'(err);
        if (sum > CMD_MAX) begin
            sum = CMD_MAX;
            r.saturated = 1'b1;
        end else if (sum < CMD_MIN) begin
            sum = CMD_MIN;
            r.saturated = 1'b1;
        end
        if (r.saturated) sum_clip_cnt++;
        err_sum_q = sum[SumW-1:0];

        // arithmetic shifts of signed values floor toward minus infinity
        p_term = (longint'(kp_q) * longint'(err)) >>> PShift;
        i_term = (longint'(ki_q) * sum * dt_l) >>> IShift;
        // signed divide truncates; step down for a negative inexact quotient
        d_num  = longint'(kd_q) * deriv * 256;
        d_term = d_num / dt_l;
        if ((d_num % dt_l) != 0 && d_num < 0) d_term = d_term - 1;

        total = p_term + i_term + d_term;
        if (total > CMD_MAX) begin
            total = CMD_MAX;
            r.saturated = 1'b1;
            cmd_clip_cnt++;
        end else if (total < CMD_MIN) begin
            total = CMD_MIN;
            r.saturated = 1'b1;
            cmd_clip_cnt++;
        end
        r.command = total[CmdW-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- driver
    // Predicts on acceptance, then inserts a gap burst, presents the next queued request
    // or drops tvalid when the queue is empty. tvalid holds until the request is taken.
    always @(posedge i_clk) begin
        t_pid_req nxt;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                cmd_expect_q.push_back(regulate_step(s_axis_tuser, s_axis_tdata[ErrW-1:0],
                                                     s_axis_tdata[InDataW-1:ErrW]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    if (!quiet && $urandom_range(0, 99) < src_pct) begin
                        // start a gap burst of random length
                        src_gap <= $urandom_range(0, 10);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        nxt = feed_q.pop_front();
                        s_axis_tdata  <= {nxt.dt, nxt.err};
                        s_axis_tuser  <= nxt.clear;
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_pid_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_cnt++;
                if (cmd_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("unexpected result: command %0d saturated %0b interval_zero %0b",
                                 $signed(m_axis_tdata), m_axis_tuser[0], m_axis_tuser[1]);
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (m_axis_tdata !== want.command || m_axis_tuser[0] !== want.saturated ||
                        m_axis_tuser[1] !== want.interval_zero) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"mismatch on result %0d: command exp %0d got %0d, ",
                                      "saturated exp %0b got %0b, interval_zero exp %0b got %0b"},
                                     result_cnt, want.command, $signed(m_axis_tdata),
                                     want.saturated, m_axis_tuser[0],
                                     want.interval_zero, m_axis_tuser[1]);
                    end
                end
            end
            // sink stalls start at any cycle, so they land on every stage of the work
            if (sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < sink_pct) begin
                sink_stall <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, cmd_expect_q.size());
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequencer helpers
    // Gain write; only issued while the block is idle.
    task automatic write_gain(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KP:  kp_q = val;
            CFG_KI:  ki_q = val;
            CFG_KD:  kd_q = val;
            default: ;  // out-of-range index is dropped
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                             input logic [GainW-1:0] kd);
        write_gain(CFG_KP, kp);
        write_gain(CFG_KI, ki);
        write_gain(CFG_UNUSED, 16'($urandom));
        write_gain(CFG_KD, kd);
        gain_sets++;
    endtask

    task automatic queue_req(input logic clear, input logic [ErrW-1:0] err,
                             input logic [DtW-1:0] dt);
        t_pid_req r;
        r.clear = clear;
        r.err   = err;
        r.dt    = dt;
        feed_q.push_back(r);
    endtask

    // wait until every request is taken and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (feed_q.size() != 0 || s_axis_tvalid || cmd_expect_q.size() != 0);
    endtask

    // Random request: mostly regulating steps, some clears and skipped steps, extremes
    // of error and interval mixed in; runs of a held error let the integral build up.
    function automatic t_pid_req random_req(input logic [ErrW-1:0] prev_err);
        t_pid_req r;
        r.clear = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 7))
            0:       r.dt = '0;
            1:       r.dt = 16'hFFFF;
            2:       r.dt = 16'($urandom_range(1, 4));
            3:       r.dt = 16'($urandom_range(1, 255));
            default: r.dt = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       r.err = 16'h7FFF;
            1:       r.err = 16'h8000;
            2:       r.err = 16'($urandom_range(0, 64)) - 16'd32;
            3, 4:    r.err = prev_err;
            default: r.err = 16'($urandom);
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- sequencer
    initial begin
        int       phase;
        t_pid_req r;
        logic [ErrW-1:0] prev;
        logic [GainW-1:0] g_kp, g_ki, g_kd;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at reset gains
        @(negedge i_clk);
        queue_req(1'b1, 16'h7FFF, 16'hFFFF);    // clear ignores error and interval
        queue_req(1'b0, 16'h7FFF, 16'hFFFF);    // largest error, longest interval
        queue_req(1'b0, 16'h8000, 16'h0001);    // swing to most negative, shortest interval
        queue_req(1'b0, 16'h0000, 16'h0000);    // zero interval: skipped
        queue_req(1'b0, 16'h8000, 16'h0000);    // skipped, previous error must stay
        queue_req(1'b0, 16'h7FFF, 16'h0001);    // full positive swing
        queue_req(1'b0, 16'h0000, 16'h8000);
        queue_req(1'b1, 16'h8000, 16'h0000);    // clear with zero interval is still a clear
        queue_req(1'b0, 16'hFFFF, 16'hFFFF);
        queue_req(1'b0, 16'h0001, 16'h0002);
        queue_req(1'b0, 16'h0001, 16'h0003);    // error unchanged: zero derivative term
        queue_req(1'b0, 16'hFFFF, 16'h0003);    // derivative of -2 divides exactly by the interval of 3
        queue_req(1'b0, 16'h7FFF, 16'h0001);
        queue_req(1'b0, 16'h7FFF, 16'h0001);
        queue_req(1'b0, 16'h7FFF, 16'hFFFF);
        queue_req(1'b1, 16'h0000, 16'h1234);
        queue_req(1'b0, 16'h8000, 16'hFFFF);
        queue_req(1'b0, 16'h8000, 16'h0000);
        drain();

        // random phases over several gain settings, extremes first
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin g_kp = 16'h7FFF; g_ki = 16'h7FFF; g_kd = 16'h8000; end
                1: begin g_kp = 16'h8000; g_ki = 16'h8000; g_kd = 16'h7FFF; end
                2: begin g_kp = 16'h0000; g_ki = 16'h0000; g_kd = 16'h0000; end
                3: begin g_kp = KP_RESET; g_ki = 16'h0010; g_kd = KD_RESET; end
                default: begin
                    g_kp = 16'($urandom);
                    g_ki = 16'($urandom);
                    g_kd = 16'($urandom);
                end
            endcase
            set_gains(g_kp, g_ki, g_kd);
            @(negedge i_clk);
            case ($urandom_range(0, 2))
                0:       begin src_pct = 0;  sink_pct = 0; end    // back-to-back stretch
                1:       begin src_pct = 15; sink_pct = 3; end
                default: begin src_pct = 40; sink_pct = 8; end
            endcase
            prev = 16'($urandom);
            repeat (RAND_PER_PHASE) begin
                r = random_req(prev);
                prev = r.err;
                feed_q.push_back(r);
            end
            drain();
        end

        // last part, no idling: hold the most negative error so the integral builds,
        // then a few steps that swing it back
        quiet = 1'b1;
        set_gains(KP_RESET, 16'h0064, KD_RESET);
        @(negedge i_clk);
        queue_req(1'b1, '0, '0);
        repeat (CLIMB_STEPS) queue_req(1'b0, 16'h8000, 16'($urandom_range(1, 65535)));
        repeat (3) queue_req(1'b0, 16'h7FFF, 16'($urandom_range(1, 65535)));
        drain();

        // let any stray result surface before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cmd_expect_q.size() != 0) err_cnt++;

        $display("ran %0d requests over %0d gain settings: %0d clears, %0d skipped steps",
                 req_cnt, gain_sets, clear_cnt, skip_cnt);
        $display({"%0d results checked, integral clipped %0d times, ",
                  "command clipped %0d times, %0d errors"},
                 result_cnt, sum_clip_cnt, cmd_clip_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* pid_controller_step.f */
+incdir+hw/rtl
hw/rtl/pid_pkg.sv
hw/rtl/pid_ctrl.sv
hw/rtl/pid_datapath.sv
hw/rtl/pid_controller_step.sv
hw/rtl/pid_checker.sv
test/pid_controller_step_test.sv
